/* hw/rtl/lsia_pkg.sv */
// ----------------------------------------------------------------------------
// lsia_pkg
// Shared types and codes for the indexed-access lifo stack.
// ----------------------------------------------------------------------------
package lsia_pkg;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	// command codes
	localparam cmd_t CMD_PUSH   = 3'd0;
	localparam cmd_t CMD_POP    = 3'd1;
	localparam cmd_t CMD_PEEK   = 3'd2;
	localparam cmd_t CMD_CHANGE = 3'd3;
	localparam cmd_t CMD_CLEAR  = 3'd4;

	// status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic push;   // shift entries away from the top, cell 0 takes new word
		logic pop;    // shift entries toward the top
		logic wr;     // overwrite the cell whose index matches
		logic load;   // copy entries into the read line
		logic shift;  // move the read line one cell toward the top
	} cell_ctl_t;

endpackage

/* hw/rtl/lsia_req_if.sv */
// ----------------------------------------------------------------------------
// lsia_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface lsia_req_if #(
	parameter int CNT_W = 4,
	parameter int WIDTH = 32
);
	logic             valid;
	logic             ready;
	lsia_pkg::cmd_t   cmd;
	logic [CNT_W-1:0] position;
	logic [WIDTH-1:0] data_in;

	modport source (output valid, cmd, position, data_in, input ready);
	modport sink   (input valid, cmd, position, data_in, output ready);
endinterface

/* hw/rtl/lsia_rsp_if.sv */
// ----------------------------------------------------------------------------
// lsia_rsp_if
// Result channel: valid/ready handshake with status, read word and fill state.
// ----------------------------------------------------------------------------
interface lsia_rsp_if #(
	parameter int CNT_W = 4,
	parameter int WIDTH = 32
);
	logic              valid;
	logic              ready;
	lsia_pkg::status_t status;
	logic [WIDTH-1:0]  read_data;
	logic [CNT_W-1:0]  fill_count;
	logic              is_full;
	logic              is_empty;

	modport source (output valid, status, read_data, fill_count, is_full, is_empty,
		input ready);
	modport sink   (input valid, status, read_data, fill_count, is_full, is_empty,
		output ready);
endinterface

/* hw/rtl/lifo_stack_with_indexed_access_core.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_indexed_access_core
// Bounded lifo stack with peek and overwrite at a depth counted from the top.
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH cells with the top word in cell 0; push
// and pop move every entry one cell at once, and an overwrite hits the
// matching cell directly. Push, pop, change, clear and rejected commands
// return their result in the output register, and a new command is taken in
// the cycle that result is taken, so they run at one per cycle while results
// are taken. A successful peek at position p copies the entries into a read
// line that shifts one cell per cycle toward cell 0; no new command is taken
// until the walk ends and the word is in the output register. The capacity
// limit register keeps the written value, the effective limit saturates at
// DEPTH, and the register resets to CAP_RESET (or DEPTH if smaller).
// ----------------------------------------------------------------------------
module lifo_stack_with_indexed_access_core #(
	parameter int DEPTH     = 8,
	parameter int WIDTH     = 32,
	parameter int CAP_RESET = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [$clog2(DEPTH+1)-1:0] cfg_wr_data,
	lsia_req_if.sink                   req,
	lsia_rsp_if.source                 rsp
);
	import lsia_pkg::*;

	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] walk_q;

	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [WIDTH-1:0] rsp_data_q;
	logic [CNT_W-1:0] rsp_count_q;
	logic             rsp_full_q;
	logic             rsp_empty_q;

	logic [WIDTH-1:0] entry_w [DEPTH];
	logic [WIDTH-1:0] rl_w    [DEPTH];

	logic             accept;
	logic             is_zero;
	logic             pos_bad;
	logic [CNT_W-1:0] eff_lim;
	logic [CNT_W-1:0] new_count;
	status_t          new_status;
	logic             go_walk;
	cell_ctl_t        ctl;

	// effective limit and command decode
	assign eff_lim = (lim_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : lim_q;
	assign is_zero = (count_q == '0);
	assign pos_bad = (req.position == '0) || (req.position > count_q);

	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		new_count  = count_q;
		new_status = ST_OK;
		go_walk    = 1'b0;
		ctl        = '0;
		case (req.cmd)
			CMD_PUSH: begin
				if (count_q >= eff_lim) begin
					new_status = ST_FULL;
				end else begin
					ctl.push  = accept;
					new_count = CNT_W'(count_q + 1'b1);
				end
			end
			CMD_POP: begin
				if (is_zero) begin
					new_status = ST_EMPTY;
				end else begin
					ctl.pop   = accept;
					new_count = CNT_W'(count_q - 1'b1);
				end
			end
			CMD_PEEK: begin
				if (is_zero) begin
					new_status = ST_EMPTY;
				end else if (pos_bad) begin
					new_status = ST_RANGE;
				end else begin
					ctl.load = accept;
					go_walk  = 1'b1;
				end
			end
			CMD_CHANGE: begin
				if (is_zero) begin
					new_status = ST_EMPTY;
				end else if (pos_bad) begin
					new_status = ST_RANGE;
				end else begin
					ctl.wr = accept;
				end
			end
			CMD_CLEAR: begin
				new_count = '0;
			end
			default: begin
				new_count = count_q;
			end
		endcase
		// read line walk toward cell 0
		if (state_q == ST_WALK && walk_q != '0) begin
			ctl.shift = 1'b1;
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] prev_e;
		logic [WIDTH-1:0] next_e;
		logic [WIDTH-1:0] next_r;

		if (i == 0) begin : g_first
			assign prev_e = req.data_in;
		end else begin : g_mid
			assign prev_e = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = entry_w[i];
			assign next_r = rl_w[i];
		end else begin : g_inner
			assign next_e = entry_w[i+1];
			assign next_r = rl_w[i+1];
		end

		lsia_cell #(
			.WIDTH (WIDTH),
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wr_idx     (CNT_W'(req.position - 1'b1)),
			.wr_data    (req.data_in),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.next_rl    (next_r),
			.entry      (entry_w[i]),
			.rl         (rl_w[i])
		);
	end

	// capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= CNT_W'(CAP_INIT);
		end else if (cfg_wr_en) begin
			lim_q <= cfg_wr_data;
		end
	end

	// sequencer, fill count and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= new_count;
						if (go_walk) begin
							state_q <= ST_WALK;
							walk_q  <= CNT_W'(req.position - 1'b1);
						end
					end
				end
				ST_WALK: begin
					if (walk_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						walk_q <= CNT_W'(walk_q - 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((accept && !go_walk) || (state_q == ST_WALK && walk_q == '0)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && !go_walk) begin
			rsp_status_q <= new_status;
			rsp_data_q   <= '0;
			rsp_count_q  <= new_count;
			rsp_full_q   <= (new_count >= eff_lim);
			rsp_empty_q  <= (new_count == '0);
		end else if (state_q == ST_WALK && walk_q == '0) begin
			rsp_status_q <= ST_OK;
			rsp_data_q   <= rl_w[0];
			rsp_count_q  <= count_q;
			rsp_full_q   <= (count_q >= eff_lim);
			rsp_empty_q  <= is_zero;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_data  = rsp_data_q;
	assign rsp.fill_count = rsp_count_q;
	assign rsp.is_full    = rsp_full_q;
	assign rsp.is_empty   = rsp_empty_q;

endmodule

/* hw/rtl/lsia_cell.sv */
// ----------------------------------------------------------------------------
// lsia_cell
// One stack slot: holds an entry and one stage of the read line, and trades
// both with its neighbors on push, pop and read-line shifts.
// ----------------------------------------------------------------------------
module lsia_cell #(
	parameter int WIDTH = 32,
	parameter int CNT_W = 4,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  lsia_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]    wr_idx,
	input  logic [WIDTH-1:0]    wr_data,
	input  logic [WIDTH-1:0]    prev_entry,
	input  logic [WIDTH-1:0]    next_entry,
	input  logic [WIDTH-1:0]    next_rl,
	output logic [WIDTH-1:0]    entry,
	output logic [WIDTH-1:0]    rl
);
	import lsia_pkg::*;

	logic [WIDTH-1:0] entry_q;
	logic [WIDTH-1:0] rl_q;
	logic             hit;

	assign hit = (wr_idx == CNT_W'(IDX));

	// entry update: push, pop or indexed overwrite
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= prev_entry;
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end else if (ctl.wr && hit) begin
			entry_q <= wr_data;
		end
	end

	// read line stage
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rl_q <= entry_q;
		end else if (ctl.shift) begin
			rl_q <= next_rl;
		end
	end

	assign entry = entry_q;
	assign rl    = rl_q;

endmodule
